// File: sv/lpf_pkg.sv
// shared widths and types for the largest prime factor block
package lpf_pkg;

    localparam int VALUE_BITS = 32;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0] word_t;
    typedef logic [VALUE_BITS:0]   rem_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

endpackage

// File: sv/largest_prime_factor.sv
// largest prime factor by trial division with a bit-serial divider
//
//   channel   ports                          handshake
//   input     value                          start, taken when busy is low
//   result    largest_factor, found          done, high for one cycle
//
// each trial divisor costs one division in the radix-2 restoring divider
// followed by a test state; factors of two are divided out in the halve state.
// a 32-bit prime needs about 32768 divisors.
// values 0 and 1 raise done in the next cycle with found low.
// reset clears the control state; busy stays high until the result is shown.
// the result is held: it stays on largest_factor and found until the next done.
module largest_prime_factor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] value,
    output logic        busy,
    output logic        done,
    output logic [31:0] largest_factor,
    output logic        found
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HALVE = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_TEST  = 2'd3;

    localparam int W = lpf_pkg::VALUE_BITS;

    logic [1:0]     state_reg, state_next;
    logic           done_reg, done_next;
    lpf_pkg::word_t n_reg, n_next;
    lpf_pkg::word_t d_reg, d_next;
    lpf_pkg::word_t best_reg, best_next;
    lpf_pkg::word_t quo_reg, quo_next;
    lpf_pkg::rem_t  rem_reg, rem_next;
    lpf_pkg::cnt_t  cnt_reg, cnt_next;
    logic           inner_reg, inner_next;
    logic [31:0]    factor_reg, factor_next;
    logic           found_reg, found_next;

    lpf_pkg::word_t value_w;
    lpf_pkg::rem_t  shifted;
    lpf_pkg::rem_t  diff;

    assign value_w = lpf_pkg::word_t'(value);
    assign shifted = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        n_next      = n_reg;
        d_next      = d_reg;
        best_next   = best_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        inner_next  = inner_reg;
        factor_next = factor_reg;
        found_next  = found_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next    = value_w;
                    best_next = '0;
                    if (value_w < lpf_pkg::word_t'(2))
                    begin
                        done_next   = 1'b1;
                        factor_next = '0;
                        found_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_HALVE;
                    end
                end
            end
            S_HALVE:
            begin
                if (!n_reg[0])
                begin
                    n_next    = n_reg >> 1;
                    best_next = lpf_pkg::word_t'(2);
                end
                else
                begin
                    d_next     = lpf_pkg::word_t'(3);
                    inner_next = 1'b0;
                    quo_next   = n_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // one quotient bit per cycle
                if (!diff[W])
                begin
                    rem_next = diff;
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + lpf_pkg::cnt_t'(1);
                if (cnt_reg == lpf_pkg::cnt_t'(W - 1))
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                rem_next = '0;
                cnt_next = '0;
                if (!inner_reg && (d_reg > quo_reg))
                begin
                    // no divisor left below the square root
                    done_next   = 1'b1;
                    found_next  = 1'b1;
                    factor_next = (n_reg > lpf_pkg::word_t'(2)) ? 32'(n_reg) : 32'(best_reg);
                    state_next  = S_IDLE;
                end
                else if (rem_reg == '0)
                begin
                    // divide out and try the same divisor again
                    best_next  = d_reg;
                    n_next     = quo_reg;
                    inner_next = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    d_next     = d_reg + lpf_pkg::word_t'(2);
                    inner_next = 1'b0;
                    quo_next   = n_reg;
                    state_next = S_DIV;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        d_reg      <= d_next;
        best_reg   <= best_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        inner_reg  <= inner_next;
        factor_reg <= factor_next;
        found_reg  <= found_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign largest_factor = factor_reg;
    assign found          = found_reg;

endmodule
